>>> src/wpcc_pkg.sv
// shared types and constants for the windowed pair co-occurrence counter
// no dependencies; imported by every module of the block except the ram
package wpcc_pkg;

  // request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ACCESS = 2'd1,
    REQ_READ   = 2'd2
  } req_e;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS = 2'd1;

  // reset values of the window lengths
  localparam logic [15:0] ON_TICKS_RST  = 16'd10;
  localparam logic [15:0] OFF_TICKS_RST = 16'd90;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // reciprocal division of the read index by the way count
  localparam int RECIP_SHIFT = 20;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] access_id;
    logic [11:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic        entry_valid;
    logic [63:0] key_first;
    logic [63:0] key_second;
    logic [31:0] pair_count;
    logic [31:0] events_total;
    logic [31:0] pairs_total;
    logic        window_is_on;
  } out_word_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_CLOSE  = 2'd1,
    CMD_READ   = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [63:0] id;
    logic [11:0] idx;
    logic [11:0] qset;
    logic [31:0] events;
    logic        win;
  } cmd_t;

  // one way of a table set
  typedef struct packed {
    logic        valid;
    logic [63:0] first;
    logic [63:0] second;
    logic [31:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_LOAD_A,
    B_WAIT_A,
    B_LOAD_B,
    B_WAIT_B,
    B_HASH,
    B_TREAD,
    B_TUPDATE
  } back_state_e;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

>>> src/wpcc_ram.sv
// generic single write port ram with registered read
// no dependencies
module wpcc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/wpcc_queue.sv
// short command queue between front and back
// depends on wpcc_pkg
module wpcc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  wpcc_pkg::cmd_t push_cmd,
  input  logic          pop,
  output wpcc_pkg::cmd_t head_cmd,
  output logic          empty,
  output logic          full
);
  import wpcc_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == QCNT_W'(QDEPTH));
  assign head_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

>>> src/wpcc_front.sv
// front: config registers, tick window tracking, event total, command build
// depends on wpcc_pkg
module wpcc_front #(
  parameter int TABLE_WAYS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  wpcc_pkg::in_word_t              item,
  input  logic                            cfg_we,
  input  logic [wpcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic                            push,
  output wpcc_pkg::cmd_t                  push_cmd
);
  import wpcc_pkg::*;

  localparam int RECIP = ((1 << RECIP_SHIFT) + TABLE_WAYS - 1) / TABLE_WAYS;

  logic [15:0] on_ticks;
  logic [15:0] off_ticks;
  logic        win_open;
  logic        win_open_next;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [15:0] tick_inc;
  logic [31:0] events_seen;
  logic [31:0] events_seen_next;
  logic [32:0] set_prod;

  // set number of the read index by reciprocal multiply
  assign set_prod = 33'(item.read_index) * 33'(RECIP);
  assign tick_inc = tick_count + 16'd1;

  // classify the word and build the command
  always_comb begin
    win_open_next    = win_open;
    tick_count_next  = tick_count;
    events_seen_next = events_seen;
    push             = 1'b0;
    push_cmd.op      = CMD_READ;
    push_cmd.id      = item.access_id;
    push_cmd.idx     = item.read_index;
    push_cmd.qset    = set_prod[RECIP_SHIFT+11:RECIP_SHIFT];
    push_cmd.events  = events_seen;
    push_cmd.win     = win_open;
    if (accept) begin
      unique case (item.req_type)
        REQ_TICK: begin
          tick_count_next = tick_inc;
          if (win_open) begin
            if (tick_inc >= on_ticks) begin
              win_open_next   = 1'b0;
              tick_count_next = '0;
              push            = 1'b1;
              push_cmd.op     = CMD_CLOSE;
            end
          end else if (tick_inc >= off_ticks) begin
            win_open_next   = 1'b1;
            tick_count_next = '0;
          end
        end
        REQ_ACCESS: begin
          if (win_open) begin
            events_seen_next = sat_inc(events_seen);
            push             = 1'b1;
            push_cmd.op      = CMD_ACCESS;
          end
        end
        REQ_READ: begin
          push        = 1'b1;
          push_cmd.op = CMD_READ;
        end
        default: begin
        end
      endcase
    end
  end

  // config and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks    <= ON_TICKS_RST;
      off_ticks   <= OFF_TICKS_RST;
      win_open    <= 1'b1;
      tick_count  <= '0;
      events_seen <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ON_TICKS:  on_ticks  <= cfg_data;
          CFG_OFF_TICKS: off_ticks <= cfg_data;
          default: begin
          end
        endcase
      end
      win_open    <= win_open_next;
      tick_count  <= tick_count_next;
      events_seen <= events_seen_next;
    end
  end
endmodule

>>> src/wpcc_back.sv
// back: ring buffer, window-close pair walk, hashed pair table, reads
// depends on wpcc_pkg and wpcc_ram
module wpcc_back #(
  parameter int BUF_DEPTH  = 256,
  parameter int TABLE_BITS = 10,
  parameter int TABLE_WAYS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  wpcc_pkg::cmd_t      head_cmd,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output wpcc_pkg::out_word_t result
);
  import wpcc_pkg::*;

  localparam int RW    = $clog2(BUF_DEPTH);
  localparam int FW    = $clog2(BUF_DEPTH + 1);
  localparam int NSETS = 1 << TABLE_BITS;
  localparam int NENT  = NSETS * TABLE_WAYS;
  localparam int WAYW  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int EW    = $bits(entry_t);
  localparam int ROWW  = EW * TABLE_WAYS;

  back_state_e state;
  back_state_e state_next;

  logic [TABLE_BITS-1:0]  clear_idx;
  logic [RW-1:0]          ring_head;
  logic [FW-1:0]          ring_fill;
  logic [RW-1:0]          pa;
  logic [RW-1:0]          pb;
  logic [FW-1:0]          i_cnt;
  logic [FW-1:0]          j_cnt;
  logic [63:0]            a_reg;
  logic [63:0]            b_reg;
  logic [63:0]            hv;
  logic [2:0]             step;
  logic [WAYW-1:0]        rd_way;
  logic                   rd_in_range;
  logic [31:0]            pairs_seen;
  cmd_t                   rd_cmd;

  // ring port
  logic                   ring_we;
  logic [RW-1:0]          ring_raddr;
  logic [63:0]            ring_rdata;

  // table port
  logic                   tbl_we;
  logic [TABLE_BITS-1:0]  tbl_waddr;
  logic [TABLE_BITS-1:0]  tbl_raddr;
  logic [ROWW-1:0]        tbl_wdata;
  logic [ROWW-1:0]        tbl_rdata;
  entry_t [TABLE_WAYS-1:0] row_in;
  entry_t [TABLE_WAYS-1:0] row_out;

  // read address decode
  logic [16:0]            set_times_ways;
  logic [11:0]            way_diff;
  logic [31:0]            head_set32;
  logic                   head_in_range;

  // close start pointer
  logic [FW:0]            start_sum;
  logic [FW:0]            start_wrap;

  // table update
  logic                   match_found;
  logic                   free_found;
  logic [WAYW-1:0]        match_way;
  logic [WAYW-1:0]        free_way;

  logic                   more_j;
  logic                   more_i;

  function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] p);
    ring_inc = (p == RW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // one step of the 64-to-32 mix
  function automatic logic [63:0] mix_step(input logic [63:0] v, input logic [2:0] s);
    logic [63:0] r;
    case (s)
      3'd0:    r = (~v) + (v << 21);
      3'd1:    r = v ^ (v >> 24);
      3'd2:    r = v + (v << 3) + (v << 8);
      3'd3:    r = v ^ (v >> 14);
      3'd4:    r = v + (v << 2) + (v << 4);
      3'd5:    r = v ^ (v >> 28);
      default: r = v + (v << 31);
    endcase
    mix_step = r;
  endfunction

  wpcc_ram #(.WIDTH(64), .DEPTH(BUF_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_head),
    .wdata (head_cmd.id),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  wpcc_ram #(.WIDTH(ROWW), .DEPTH(NSETS)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign row_in    = tbl_rdata;
  assign clearing  = (state == B_CLEAR);

  // read index to set and way
  assign set_times_ways = 17'(head_cmd.qset) * 17'(TABLE_WAYS);
  assign way_diff       = head_cmd.idx - set_times_ways[11:0];
  assign head_set32     = 32'(head_cmd.qset);
  assign head_in_range  = 32'(head_cmd.idx) < 32'(NENT);

  // oldest ring entry
  assign start_sum  = (FW+1)'(ring_head) + (FW+1)'(BUF_DEPTH) - (FW+1)'(ring_fill);
  assign start_wrap = (start_sum >= (FW+1)'(BUF_DEPTH)) ?
                      start_sum - (FW+1)'(BUF_DEPTH) : start_sum;

  // pair walk loop bounds
  assign more_j = ((FW+1)'(j_cnt) + 1'b1) < (FW+1)'(ring_fill);
  assign more_i = ((FW+1)'(i_cnt) + 2'd2) < (FW+1)'(ring_fill);

  // way search over the fetched set
  always_comb begin
    match_found = 1'b0;
    free_found  = 1'b0;
    match_way   = '0;
    free_way    = '0;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (row_in[w].valid) begin
        if (row_in[w].first == a_reg && row_in[w].second == b_reg) begin
          match_found = 1'b1;
          match_way   = WAYW'(w);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_way   = WAYW'(w);
      end
    end
  end

  // updated set
  always_comb begin
    row_out = row_in;
    if (match_found) begin
      row_out[match_way].count = sat_inc(row_in[match_way].count);
    end else if (free_found) begin
      row_out[free_way].valid  = 1'b1;
      row_out[free_way].first  = a_reg;
      row_out[free_way].second = b_reg;
      row_out[free_way].count  = 32'd1;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ring_we    = 1'b0;
    ring_raddr = pb;
    tbl_we     = 1'b0;
    tbl_waddr  = hv[TABLE_BITS-1:0];
    tbl_wdata  = row_out;
    tbl_raddr  = hv[TABLE_BITS-1:0];
    unique case (state)
      B_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clear_idx;
        tbl_wdata = '0;
        if (clear_idx == TABLE_BITS'(NSETS - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        tbl_raddr = head_set32[TABLE_BITS-1:0];
        if (!q_empty) begin
          pop = 1'b1;
          unique case (head_cmd.op)
            CMD_ACCESS: ring_we = 1'b1;
            CMD_READ:   state_next = B_READ;
            CMD_CLOSE: begin
              if (ring_fill >= FW'(2)) begin
                state_next = B_LOAD_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_READ:   state_next = B_IDLE;
      B_LOAD_A: begin
        ring_raddr = pa;
        state_next = B_WAIT_A;
      end
      B_WAIT_A: state_next = B_LOAD_B;
      B_LOAD_B: state_next = B_WAIT_B;
      B_WAIT_B: state_next = B_HASH;
      B_HASH: begin
        if (step == 3'd6) begin
          state_next = B_TREAD;
        end
      end
      B_TREAD:  state_next = B_TUPDATE;
      B_TUPDATE: begin
        tbl_we = match_found | free_found;
        if (more_j) begin
          state_next = B_LOAD_B;
        end else if (more_i) begin
          state_next = B_LOAD_A;
        end else begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control counters and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx  <= '0;
      ring_head  <= '0;
      ring_fill  <= '0;
      pairs_seen <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_CLEAR: clear_idx <= clear_idx + 1'b1;
        B_IDLE: begin
          if (!q_empty) begin
            if (head_cmd.op == CMD_ACCESS) begin
              ring_head <= ring_inc(ring_head);
              if (ring_fill < FW'(BUF_DEPTH)) begin
                ring_fill <= ring_fill + 1'b1;
              end
            end else if (head_cmd.op == CMD_CLOSE && ring_fill < FW'(2)) begin
              ring_head <= '0;
              ring_fill <= '0;
            end
          end
        end
        B_READ: done <= 1'b1;
        B_TUPDATE: begin
          pairs_seen <= sat_inc(pairs_seen);
          if (!more_j && !more_i) begin
            ring_head <= '0;
            ring_fill <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // walk datapath, hash and read capture
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        pa          <= start_wrap[RW-1:0];
        i_cnt       <= '0;
        rd_cmd      <= head_cmd;
        rd_way      <= way_diff[WAYW-1:0];
        rd_in_range <= head_in_range;
      end
      B_WAIT_A: begin
        a_reg <= ring_rdata;
        pb    <= ring_inc(pa);
        j_cnt <= i_cnt + 1'b1;
      end
      B_WAIT_B: begin
        b_reg <= ring_rdata;
        hv    <= a_reg ^ (ring_rdata << 1);
        step  <= '0;
      end
      B_HASH: begin
        hv   <= mix_step(hv, step);
        step <= step + 1'b1;
      end
      B_TUPDATE: begin
        if (more_j) begin
          pb    <= ring_inc(pb);
          j_cnt <= j_cnt + 1'b1;
        end else begin
          pa    <= ring_inc(pa);
          i_cnt <= i_cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == B_READ) begin
      if (rd_in_range && row_in[rd_way].valid) begin
        result.entry_valid <= 1'b1;
        result.key_first   <= row_in[rd_way].first;
        result.key_second  <= row_in[rd_way].second;
        result.pair_count  <= row_in[rd_way].count;
      end else begin
        result.entry_valid <= 1'b0;
        result.key_first   <= '0;
        result.key_second  <= '0;
        result.pair_count  <= '0;
      end
      result.events_total <= rd_cmd.events;
      result.pairs_total  <= pairs_seen;
      result.window_is_on <= rd_cmd.win;
    end
  end
endmodule

>>> src/windowed_pair_cooccurrence_counter.sv
// windowed pair co-occurrence counter: an item is taken per cycle while busy is low
// and commands go into a 4-word queue; a window close walks the ring, taking each
// pair through ring fetch, 7-step hash and a table read-modify-write
// busy is high while the queue is full, and after reset while the table is cleared
// results come as a one-cycle done strobe; the receiver cannot stall
module windowed_pair_cooccurrence_counter #(
  parameter int BUF_DEPTH  = 256,
  parameter int TABLE_BITS = 10,
  parameter int TABLE_WAYS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  wpcc_pkg::in_word_t             item,
  input  logic                           cfg_we,
  input  logic [wpcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           done,
  output wpcc_pkg::out_word_t            result
);
  import wpcc_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic clearing;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign busy   = q_full | clearing;
  assign accept = start & ~busy;

  wpcc_front #(.TABLE_WAYS(TABLE_WAYS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  wpcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  wpcc_back #(
    .BUF_DEPTH  (BUF_DEPTH),
    .TABLE_BITS (TABLE_BITS),
    .TABLE_WAYS (TABLE_WAYS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_cmd (head_cmd),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

  // table clear holds off input right after reset
  a_clear_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // the read state always returns to idle before another read, so strobes never touch
  a_done_spaced: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobes back to back");

  // a valid entry was counted at least once
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    done && result.entry_valid |-> result.pair_count != 32'd0)
    else $error("valid entry with zero count");

  // nothing is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push into full queue");
endmodule

>>> bench/tb.sv
// testbench for the windowed pair co-occurrence counter
// depends on wpcc_pkg and windowed_pair_cooccurrence_counter; self-checking, no files
`timescale 1ns / 1ps

module tb;
  import wpcc_pkg::*;

  localparam int RING_N     = 256;
  localparam int SETS       = 1024;
  localparam int WAYS       = 4;
  localparam int ENTRIES    = SETS * WAYS;
  localparam int IDLE_LIMIT = 2000000;
  localparam int SETTLE     = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  item = '0;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic      done;
  out_word_t result;

  windowed_pair_cooccurrence_counter u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pending word plus a flag to aim a read at an entry known to be filled
  typedef struct packed {
    in_word_t w;
    logic     aim;
  } pend_t;

  pend_t     pending[$];
  out_word_t expected_reads[$];
  int        failures = 0;

  // predictor state
  logic [15:0] p_on, p_off, p_ticks;
  logic        p_win;
  logic [63:0] p_ring[RING_N];
  logic [7:0]  p_head;
  logic [8:0]  p_fill;
  logic [63:0] p_first[ENTRIES];
  logic [63:0] p_second[ENTRIES];
  logic [31:0] p_count[ENTRIES];
  logic        p_valid[ENTRIES];
  logic [31:0] p_events, p_pairs;
  int          filled_idx[$];
  logic [63:0] id_pool[8];

  function automatic logic [31:0] bump32(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [31:0] mix64(input logic [63:0] x);
    logic [63:0] v;
    v = (~x) + (x << 21);
    v = v ^ (v >> 24);
    v = (v + (v << 3)) + (v << 8);
    v = v ^ (v >> 14);
    v = (v + (v << 2)) + (v << 4);
    v = v ^ (v >> 28);
    v = v + (v << 31);
    return v[31:0];
  endfunction

  function automatic void count_pair(input logic [63:0] a, input logic [63:0] b);
    logic [31:0] h;
    int base, slot;
    h = mix64(a ^ (b << 1));
    base = int'(h[9:0]) * WAYS;
    slot = -1;
    p_pairs = bump32(p_pairs);
    for (int w = 0; w < WAYS; w++) begin
      if (p_valid[base+w]) begin
        if (p_first[base+w] == a && p_second[base+w] == b) begin
          p_count[base+w] = bump32(p_count[base+w]);
          return;
        end
      end else if (slot < 0) begin
        slot = base + w;
      end
    end
    if (slot >= 0) begin
      p_valid[slot] = 1'b1;
      p_first[slot] = a;
      p_second[slot] = b;
      p_count[slot] = 32'd1;
      filled_idx.push_back(slot);
    end
  endfunction

  function automatic void walk_ring();
    int first_pos;
    first_pos = (int'(p_head) + RING_N - int'(p_fill)) % RING_N;
    for (int i = 0; i < p_fill; i++)
      for (int j = i + 1; j < p_fill; j++)
        count_pair(p_ring[(first_pos + i) % RING_N], p_ring[(first_pos + j) % RING_N]);
    p_head = '0;
    p_fill = '0;
  endfunction

  // update the predictor with one accepted word
  function automatic void predict_word(input in_word_t w);
    out_word_t r;
    logic [15:0] len;
    case (w.req_type)
      REQ_TICK: begin
        p_ticks = p_ticks + 16'd1;
        len = p_win ? p_on : p_off;
        if (p_ticks >= len) begin
          p_ticks = '0;
          if (p_win) begin
            p_win = 1'b0;
            walk_ring();
          end else begin
            p_win = 1'b1;
          end
        end
      end
      REQ_ACCESS: begin
        if (p_win) begin
          p_ring[p_head] = w.access_id;
          p_head = p_head + 8'd1;
          if (p_fill < RING_N) p_fill = p_fill + 9'd1;
          p_events = bump32(p_events);
        end
      end
      REQ_READ: begin
        r.entry_valid  = p_valid[w.read_index];
        r.key_first    = r.entry_valid ? p_first[w.read_index] : '0;
        r.key_second   = r.entry_valid ? p_second[w.read_index] : '0;
        r.pair_count   = r.entry_valid ? p_count[w.read_index] : '0;
        r.events_total = p_events;
        r.pairs_total  = p_pairs;
        r.window_is_on = p_win;
        expected_reads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // driver: bursts of words with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    pend_t p;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_word(item);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          p = pending.pop_front();
          if (p.aim && filled_idx.size() > 0)
            p.w.read_index = 12'(filled_idx[$urandom_range(filled_idx.size() - 1)]);
          item <= p.w;
          start <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 60)
                                                  : $urandom_range(12, 1);
            gap_left = ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                : $urandom_range(4);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && done) begin
      if (expected_reads.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        e = expected_reads.pop_front();
        if (result.entry_valid !== e.entry_valid) begin
          $error("entry_valid exp %0h got %0h", e.entry_valid, result.entry_valid);
          failures++;
        end
        if (result.key_first !== e.key_first) begin
          $error("key_first exp %0h got %0h", e.key_first, result.key_first);
          failures++;
        end
        if (result.key_second !== e.key_second) begin
          $error("key_second exp %0h got %0h", e.key_second, result.key_second);
          failures++;
        end
        if (result.pair_count !== e.pair_count) begin
          $error("pair_count exp %0h got %0h", e.pair_count, result.pair_count);
          failures++;
        end
        if (result.events_total !== e.events_total) begin
          $error("events_total exp %0h got %0h", e.events_total, result.events_total);
          failures++;
        end
        if (result.pairs_total !== e.pairs_total) begin
          $error("pairs_total exp %0h got %0h", e.pairs_total, result.pairs_total);
          failures++;
        end
        if (result.window_is_on !== e.window_is_on) begin
          $error("window_is_on exp %0h got %0h", e.window_is_on, result.window_is_on);
          failures++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word or result
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_word(input req_e op, input logic [63:0] id, input logic [11:0] idx,
                           input logic aim);
    pend_t p;
    p.w.req_type = op;
    p.w.access_id = id;
    p.w.read_index = idx;
    p.aim = aim;
    pending.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_ON_TICKS) p_on = val;
    else if (idx == CFG_OFF_TICKS) p_off = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a trailing read flushes all queued work, then let the block settle
  task automatic drain();
    push_word(REQ_READ, '0, 12'($urandom), 1'b1);
    while (pending.size() > 0 || start || expected_reads.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_random(input int n);
    int k;
    logic [63:0] id;
    pend_t p;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      id = ($urandom_range(2) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(7)];
      if (k < 42) push_word(REQ_ACCESS, id, 12'($urandom), 1'b0);
      else if (k < 80) push_word(REQ_TICK, id, 12'($urandom), 1'b0);
      else if (k < 96) push_word(REQ_READ, id, 12'($urandom), $urandom_range(3) != 0);
      else begin
        p.w.req_type = 2'b11;
        p.w.access_id = id;
        p.w.read_index = 12'($urandom);
        p.aim = 1'b0;
        pending.push_back(p);
      end
    end
  endtask

  initial begin
    p_on = ON_TICKS_RST;
    p_off = OFF_TICKS_RST;
    p_ticks = '0;
    p_win = 1'b1;
    p_head = '0;
    p_fill = '0;
    p_events = '0;
    p_pairs = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      p_valid[i] = 1'b0;
      p_first[i] = '0;
      p_second[i] = '0;
      p_count[i] = '0;
    end
    for (int i = 0; i < RING_N; i++) p_ring[i] = '0;
    for (int i = 0; i < 8; i++) id_pool[i] = {$urandom, $urandom};
    id_pool[0][63] = 1'b1;
    id_pool[1][63] = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, id extremes, ignored type, one window close
    push_word(REQ_READ, '0, 12'd0, 1'b0);
    push_word(REQ_READ, '0, 12'hFFF, 1'b0);
    push_word(REQ_ACCESS, 64'd0, '0, 1'b0);
    push_word(REQ_ACCESS, '1, '0, 1'b0);
    push_word(REQ_ACCESS, 64'h8000_0000_0000_0000, '0, 1'b0);
    push_word(REQ_ACCESS, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0);
    push_word(REQ_ACCESS, 64'd0, '0, 1'b0);
    pending.push_back('{w: '{req_type: 2'b11, access_id: '1, read_index: '1}, aim: 1'b0});
    for (int i = 0; i < 10; i++) push_word(REQ_TICK, '0, '0, 1'b0);
    push_word(REQ_ACCESS, 64'd5, '0, 1'b0);
    for (int i = 0; i < 4; i++) push_word(REQ_READ, '0, '0, 1'b1);
    drain();

    // zero lengths act as one; out-of-range indexes are dropped
    write_reg(CFG_ON_TICKS, 16'd0);
    write_reg(CFG_OFF_TICKS, 16'd0);
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h0001);
    push_random(150);
    drain();

    write_reg(CFG_ON_TICKS, 16'd1);
    write_reg(CFG_OFF_TICKS, 16'd1);
    push_random(250);
    drain();

    write_reg(CFG_ON_TICKS, 16'd12);
    write_reg(CFG_OFF_TICKS, 16'd3);
    push_random(350);
    drain();

    write_reg(CFG_ON_TICKS, 16'd4);
    write_reg(CFG_OFF_TICKS, 16'd65535);
    push_random(80);
    drain();

    write_reg(CFG_ON_TICKS, 16'd20);
    write_reg(CFG_OFF_TICKS, 16'd2);
    push_random(350);
    drain();

    // ring overrun: long window, more accesses than ring slots, then close
    write_reg(CFG_ON_TICKS, 16'd65535);
    write_reg(CFG_OFF_TICKS, 16'd1);
    push_word(REQ_TICK, '0, '0, 1'b0);
    push_word(REQ_TICK, '0, '0, 1'b0);
    for (int i = 0; i < 300; i++)
      push_word(REQ_ACCESS, ($urandom_range(1) != 0) ? {$urandom, $urandom}
                                                     : id_pool[$urandom_range(7)], '0, 1'b0);
    drain();
    write_reg(CFG_ON_TICKS, 16'd1);
    push_word(REQ_TICK, '0, '0, 1'b0);
    for (int i = 0; i < 6; i++) push_word(REQ_READ, '0, '0, 1'b1);
    push_random(200);
    drain();

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
